// ----- hdl/abse_pkg.sv -----
// Shared types and constants for the data-processing execute pipeline.
// Used by every stage module and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package abse_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned RegIdxWidth = 4;
   localparam int unsigned FlagWidth = 4;
   localparam int unsigned AmtWidth = 6;

   // Flag bit positions inside an NZCV nibble
   localparam int unsigned FlagN = 3;
   localparam int unsigned FlagZ = 2;
   localparam int unsigned FlagC = 1;
   localparam int unsigned FlagV = 0;

   localparam logic [RegIdxWidth-1:0] RegPc = 4'hF;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [3:0] {
      OP_AND = 4'h0,
      OP_EOR = 4'h1,
      OP_SUB = 4'h2,
      OP_RSB = 4'h3,
      OP_ADD = 4'h4,
      OP_ADC = 4'h5,
      OP_SBC = 4'h6,
      OP_RSC = 4'h7,
      OP_TST = 4'h8,
      OP_TEQ = 4'h9,
      OP_CMP = 4'hA,
      OP_CMN = 4'hB,
      OP_ORR = 4'hC,
      OP_MOV = 4'hD,
      OP_BIC = 4'hE,
      OP_MVN = 4'hF
   } opcode_type;

   // Shift type field of the instruction
   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_field_type;

   // Normalized shifter operation after decode of all #0 / register rules
   typedef enum logic [2:0] {
      SK_PASS = 3'd0,
      SK_LSL  = 3'd1,
      SK_LSR  = 3'd2,
      SK_ASR  = 3'd3,
      SK_ROR  = 3'd4,
      SK_RRX  = 3'd5
   } shift_kind_type;

   // Control that rides along every stage
   typedef struct packed {
      opcode_type                 opcode;
      logic [RegIdxWidth-1:0]     rd;
      logic                       writes;
      logic                       flags_wr;
      logic                       restore;
      logic                       logical;
      logic [FlagWidth-1:0]       flags;
   } ctrl_type;

   typedef struct packed {
      ctrl_type                   ctrl;
      word_type                   rn_val;
      word_type                   sh_val;
      shift_kind_type             sh_kind;
      logic [AmtWidth-1:0]        sh_amt;
   } dec_type;

   typedef struct packed {
      ctrl_type                   ctrl;
      word_type                   rn_val;
      word_type                   op2;
      logic                       sh_carry;
   } shf_type;

   typedef struct packed {
      ctrl_type                   ctrl;
      word_type                   result;
      logic                       add_c;
      logic                       add_v;
      logic                       sh_carry;
   } alu_type;

endpackage

`default_nettype wire

// ----- hdl/abse_decode.sv -----
// Stage 1: instruction decode, PC +4 fixup and shifter operation normalization.
// Depends on abse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abse_decode import abse_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [WordWidth-1:0] instr_word,
   input  wire logic [WordWidth-1:0] rn_value,
   input  wire logic [WordWidth-1:0] rm_value,
   input  wire logic [WordWidth-1:0] rs_value,
   input  wire logic [FlagWidth-1:0] flags_in,
   output logic                      out_valid,
   output dec_type                   out_data
);

   logic    valid_ff;
   dec_type data_ff, data_in;

   logic            is_imm, by_reg, s_bit;
   opcode_type      opcode;
   shift_field_type sh_field;
   logic [4:0]      imm_amt;
   logic [4:0]      rot;
   logic [7:0]      rs8;

   always_comb begin
      is_imm   = instr_word[25];
      by_reg   = !instr_word[25] && instr_word[4];
      s_bit    = instr_word[20];
      opcode   = opcode_type'(instr_word[24:21]);
      sh_field = shift_field_type'(instr_word[6:5]);
      imm_amt  = instr_word[11:7];
      rot      = {instr_word[11:8], 1'b0};
      rs8      = rs_value[7:0];

      data_in.ctrl.opcode = opcode;
      data_in.ctrl.rd     = instr_word[15:12];
      data_in.ctrl.flags  = flags_in;
      data_in.ctrl.writes = !(opcode inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
      data_in.ctrl.logical = opcode inside {OP_AND, OP_EOR, OP_TST, OP_TEQ,
                                            OP_ORR, OP_MOV, OP_BIC, OP_MVN};
      data_in.ctrl.restore  = s_bit && (instr_word[15:12] == RegPc) && data_in.ctrl.writes;
      data_in.ctrl.flags_wr = s_bit && !data_in.ctrl.restore;

      // PC reads as address+12 under a register-specified shift
      data_in.rn_val = rn_value;
      if (by_reg && (instr_word[19:16] == RegPc)) begin
         data_in.rn_val = rn_value + WordWidth'(4);
      end

      data_in.sh_val  = rm_value;
      data_in.sh_kind = SK_PASS;
      data_in.sh_amt  = '0;
      if (is_imm) begin
         data_in.sh_val  = {{(WordWidth-8){1'b0}}, instr_word[7:0]};
         data_in.sh_kind = (rot == 5'd0) ? SK_PASS : SK_ROR;
         data_in.sh_amt  = {1'b0, rot};
      end else if (by_reg) begin
         if (instr_word[3:0] == RegPc) begin
            data_in.sh_val = rm_value + WordWidth'(4);
         end
         if (rs8 == 8'd0) begin
            data_in.sh_kind = SK_PASS;
         end else begin
            case (sh_field)
               SH_LSL: begin
                  data_in.sh_kind = SK_LSL;
                  data_in.sh_amt  = (rs8 > 8'd32) ? AmtWidth'(33) : rs8[AmtWidth-1:0];
               end
               SH_LSR: begin
                  data_in.sh_kind = SK_LSR;
                  data_in.sh_amt  = (rs8 > 8'd32) ? AmtWidth'(33) : rs8[AmtWidth-1:0];
               end
               SH_ASR: begin
                  data_in.sh_kind = SK_ASR;
                  data_in.sh_amt  = (rs8 >= 8'd32) ? AmtWidth'(32) : rs8[AmtWidth-1:0];
               end
               default: begin
                  // amount a multiple of 32: value unchanged, carry = bit 31
                  data_in.sh_kind = SK_ROR;
                  data_in.sh_amt  = {1'b0, rs8[4:0]};
               end
            endcase
         end
      end else begin
         case (sh_field)
            SH_LSL: begin
               data_in.sh_kind = (imm_amt == 5'd0) ? SK_PASS : SK_LSL;
               data_in.sh_amt  = {1'b0, imm_amt};
            end
            SH_LSR: begin
               data_in.sh_kind = SK_LSR;
               data_in.sh_amt  = (imm_amt == 5'd0) ? AmtWidth'(32) : {1'b0, imm_amt};
            end
            SH_ASR: begin
               data_in.sh_kind = SK_ASR;
               data_in.sh_amt  = (imm_amt == 5'd0) ? AmtWidth'(32) : {1'b0, imm_amt};
            end
            default: begin
               data_in.sh_kind = (imm_amt == 5'd0) ? SK_RRX : SK_ROR;
               data_in.sh_amt  = {1'b0, imm_amt};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/abse_shifter.sv -----
// Stage 2: barrel shifter producing operand 2 and the shifter carry.
// Depends on abse_pkg; fed by abse_decode.
`timescale 1ns / 1ps
`default_nettype none

module abse_shifter import abse_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire dec_type in_data,
   output logic         out_valid,
   output shf_type      out_data
);

   logic    valid_ff;
   shf_type data_ff, data_in;

   logic                   cin;
   logic [2*WordWidth:0]   lsl_wide;
   logic [WordWidth:0]     lsr_wide;
   logic [WordWidth:0]     asr_wide;
   logic [2*WordWidth-1:0] ror_wide;

   always_comb begin
      cin = in_data.ctrl.flags[FlagC];
      // extra bit below or above the word catches the last bit shifted out
      lsl_wide = {{(WordWidth+1){1'b0}}, in_data.sh_val} << in_data.sh_amt;
      lsr_wide = {in_data.sh_val, 1'b0} >> in_data.sh_amt;
      asr_wide = $signed({in_data.sh_val, 1'b0}) >>> in_data.sh_amt;
      ror_wide = {in_data.sh_val, in_data.sh_val} >> in_data.sh_amt[4:0];

      data_in.ctrl   = in_data.ctrl;
      data_in.rn_val = in_data.rn_val;
      case (in_data.sh_kind)
         SK_LSL: begin
            data_in.op2      = lsl_wide[WordWidth-1:0];
            data_in.sh_carry = lsl_wide[WordWidth];
         end
         SK_LSR: begin
            data_in.op2      = lsr_wide[WordWidth:1];
            data_in.sh_carry = lsr_wide[0];
         end
         SK_ASR: begin
            data_in.op2      = asr_wide[WordWidth:1];
            data_in.sh_carry = asr_wide[0];
         end
         SK_ROR: begin
            data_in.op2      = ror_wide[WordWidth-1:0];
            data_in.sh_carry = ror_wide[WordWidth-1];
         end
         SK_RRX: begin
            data_in.op2      = {cin, in_data.sh_val[WordWidth-1:1]};
            data_in.sh_carry = in_data.sh_val[0];
         end
         default: begin
            data_in.op2      = in_data.sh_val;
            data_in.sh_carry = cin;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/abse_alu.sv -----
// Stage 3: adder and logic unit for all sixteen opcodes.
// Depends on abse_pkg; fed by abse_shifter.
`timescale 1ns / 1ps
`default_nettype none

module abse_alu import abse_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire shf_type in_data,
   output logic         out_valid,
   output alu_type      out_data
);

   logic    valid_ff;
   alu_type data_ff, data_in;

   word_type           add_x, add_y, sum;
   logic               add_ci;
   logic [WordWidth:0] sum_wide;
   logic               cin;

   always_comb begin
      cin    = in_data.ctrl.flags[FlagC];
      add_x  = in_data.rn_val;
      add_y  = in_data.op2;
      add_ci = 1'b0;
      case (in_data.ctrl.opcode)
         OP_SUB, OP_CMP: begin
            add_y  = ~in_data.op2;
            add_ci = 1'b1;
         end
         OP_RSB: begin
            add_x  = in_data.op2;
            add_y  = ~in_data.rn_val;
            add_ci = 1'b1;
         end
         OP_ADC: begin
            add_ci = cin;
         end
         OP_SBC: begin
            add_y  = ~in_data.op2;
            add_ci = cin;
         end
         OP_RSC: begin
            add_x  = in_data.op2;
            add_y  = ~in_data.rn_val;
            add_ci = cin;
         end
         default: begin
            add_ci = 1'b0;
         end
      endcase
      sum_wide = {1'b0, add_x} + {1'b0, add_y} + {{WordWidth{1'b0}}, add_ci};
      sum      = sum_wide[WordWidth-1:0];

      data_in.ctrl     = in_data.ctrl;
      data_in.sh_carry = in_data.sh_carry;
      data_in.add_c    = sum_wide[WordWidth];
      data_in.add_v    = (~(add_x[WordWidth-1] ^ add_y[WordWidth-1]))
                         & (add_x[WordWidth-1] ^ sum[WordWidth-1]);
      case (in_data.ctrl.opcode)
         OP_AND, OP_TST: data_in.result = in_data.rn_val & in_data.op2;
         OP_EOR, OP_TEQ: data_in.result = in_data.rn_val ^ in_data.op2;
         OP_ORR:         data_in.result = in_data.rn_val | in_data.op2;
         OP_MOV:         data_in.result = in_data.op2;
         OP_BIC:         data_in.result = in_data.rn_val & ~in_data.op2;
         OP_MVN:         data_in.result = ~in_data.op2;
         default:        data_in.result = sum;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/alu_barrel_shifter_execute.sv -----
// Top level of the data-processing execute pipeline: three stage modules
// plus the flag and output register stage. Depends on abse_pkg and all abse_* stages.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel: a beat (instruction word, Rn/Rm/Rs values, NZCV) is taken
//   at a rising edge where start is high and busy is low. busy is high only
//   while reset is asserted, so outside reset a new beat can enter every cycle.
//   Result channel: rsp_valid strobes for exactly one cycle per beat with the
//   result, destination, write enable, new flags and the SPSR restore request.
//   The receiver cannot hold results off; none is needed, the pipe never stalls.
//   Path: a beat passes through the stage registers, in order:
//   decode/PC fixup, barrel shifter, 32-bit adder/logic, flag formation.
//   Throughput: 1 beat per cycle, set by one pass through each stage register.
//   Results leave in acceptance order.
//   Reset (synchronous, active high) clears all stage valid bits; beats in
//   flight are dropped and no result strobes until new beats arrive.

module alu_barrel_shifter_execute import abse_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [WordWidth-1:0]   req_instr_word,
   input  wire logic [WordWidth-1:0]   req_rn_value,
   input  wire logic [WordWidth-1:0]   req_rm_value,
   input  wire logic [WordWidth-1:0]   req_rs_value,
   input  wire logic [FlagWidth-1:0]   req_flags_in,
   output logic                        rsp_valid,
   output logic [WordWidth-1:0]        rsp_alu_result,
   output logic [RegIdxWidth-1:0]      rsp_dest_index,
   output logic                        rsp_dest_write,
   output logic [FlagWidth-1:0]        rsp_flags_out,
   output logic                        rsp_flags_written,
   output logic                        rsp_restore_psr
);

   logic    accept;
   logic    dec_valid, shf_valid, alu_valid;
   dec_type dec_data;
   shf_type shf_data;
   alu_type alu_data;

   // output stage registers
   logic                   valid_ff;
   word_type               result_ff;
   logic [RegIdxWidth-1:0] dest_ff;
   logic                   dest_wr_ff;
   logic [FlagWidth-1:0]   flags_ff, flags_in;
   logic                   flags_wr_ff;
   logic                   restore_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   abse_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .instr_word (req_instr_word),
      .rn_value   (req_rn_value),
      .rm_value   (req_rm_value),
      .rs_value   (req_rs_value),
      .flags_in   (req_flags_in),
      .out_valid  (dec_valid),
      .out_data   (dec_data)
   );

   abse_shifter u_shifter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_data   (dec_data),
      .out_valid (shf_valid),
      .out_data  (shf_data)
   );

   abse_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (shf_valid),
      .in_data   (shf_data),
      .out_valid (alu_valid),
      .out_data  (alu_data)
   );

   // Flag formation: logical ops take the shifter carry and keep V;
   // without a normal S update (or on an SPSR restore) flags pass through.
   always_comb begin
      flags_in = alu_data.ctrl.flags;
      if (alu_data.ctrl.flags_wr) begin
         flags_in[FlagN] = alu_data.result[WordWidth-1];
         flags_in[FlagZ] = (alu_data.result == '0);
         flags_in[FlagC] = alu_data.ctrl.logical ? alu_data.sh_carry : alu_data.add_c;
         flags_in[FlagV] = alu_data.ctrl.logical ? alu_data.ctrl.flags[FlagV]
                                                 : alu_data.add_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= alu_valid;
      end
      result_ff   <= alu_data.result;
      dest_ff     <= alu_data.ctrl.rd;
      dest_wr_ff  <= alu_data.ctrl.writes;
      flags_ff    <= flags_in;
      flags_wr_ff <= alu_data.ctrl.flags_wr;
      restore_ff  <= alu_data.ctrl.restore;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_alu_result    = result_ff;
   assign rsp_dest_index    = dest_ff;
   assign rsp_dest_write    = dest_wr_ff;
   assign rsp_flags_out     = flags_ff;
   assign rsp_flags_written = flags_wr_ff;
   assign rsp_restore_psr   = restore_ff;

   // Every accepted beat comes out as a result strobe, and no strobe comes without one.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(reset, 2) && !$past(reset, 3))
      |-> (rsp_valid == $past(accept, 4)))
      else $error("result strobe does not match accepted beat");

   // Untouched flags must be the flags that came in with the beat.
   a_flags_pass: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(reset, 2) && !$past(reset, 3)
       && rsp_valid && !rsp_flags_written)
      |-> (rsp_flags_out == $past(req_flags_in, 4)))
      else $error("flags changed without a flag update");

   a_restore_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_restore_psr && rsp_flags_written))
      else $error("restore request together with a normal flag update");

   a_restore_dest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_restore_psr) |-> (rsp_dest_write && (rsp_dest_index == RegPc)))
      else $error("restore request without a write to PC");

endmodule

`default_nettype wire
